// ----- hw/rtl/ccra_pkg.sv -----
// ----------------------------------------------------------------------------
// ccra_pkg
// Shared constants and controller/datapath types for the row allocator.
// ----------------------------------------------------------------------------
package ccra_pkg;

  localparam int MAX_ROWS     = 32;
  localparam int MAX_CONTEXTS = 4;
  localparam int STORE_DEPTH  = MAX_ROWS * MAX_CONTEXTS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int IDX_W        = 8;   // flat index incl. offset / row overrun
  localparam int STEP_W       = 8;   // jump and row counters
  localparam int SUM_W        = 38;  // up to 63 load times of 32 bits

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALIGNMENT = 2'd2;

  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_ALLOCATE = 1'b1;

  typedef struct packed {
    logic accept;
    logic wr;
    logic dbl_align;
    logic init_jump;
    logic dbl_jump;
    logic init_row;
    logic step_row;
    logic init_ctx;
    logic latch_base;
    logic set_hit;
    logic sum_init;
    logic sum_step;
    logic cmp;
    logic out_load;
  } ccra_cmd_t;

  typedef struct packed {
    logic align_lt_want;
    logic jump_le_rows;
    logic row_lt_rows;
    logic ctx_lt_n;
    logic tag_hit;
    logic sum_done;
  } ccra_sts_t;

endpackage

// ----- hw/rtl/ccra_if.sv -----
// ----------------------------------------------------------------------------
// ccra_in_if / ccra_out_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface ccra_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [1:0]  context_index;
  logic [4:0]  row_index;
  logic [31:0] config_address;
  logic [31:0] load_time;
  logic [5:0]  rows_wanted;
  logic [4:0]  tag_row_offset;

  modport source (output valid, req_type, context_index, row_index, config_address,
                  load_time, rows_wanted, tag_row_offset, input ready);
  modport sink   (input valid, req_type, context_index, row_index, config_address,
                  load_time, rows_wanted, tag_row_offset, output ready);
endinterface

interface ccra_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] start_row;
  logic [5:0] end_row;
  logic       hit;
  logic       found;

  modport source (output valid, start_row, end_row, hit, found, input ready);
  modport sink   (input valid, start_row, end_row, hit, found, output ready);
endinterface

// ----- hw/rtl/ccra_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccra_ctrl
// Search sequencer: steps alignment, jump, row, context and load-time sum.
// ----------------------------------------------------------------------------
module ccra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  ccra_pkg::ccra_sts_t sts,
  output ccra_pkg::ccra_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ALIGN  = 4'd1;
  localparam logic [3:0] S_JUMP   = 4'd2;
  localparam logic [3:0] S_ROW    = 4'd3;
  localparam logic [3:0] S_CTX    = 4'd4;
  localparam logic [3:0] S_TAG    = 4'd5;
  localparam logic [3:0] S_SUM    = 4'd6;
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_RESULT = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_req_type == ccra_pkg::REQ_WRITE) begin
            cmd.wr    = 1'b1;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_ALIGN;
          end
        end
      end
      S_ALIGN: begin
        if (sts.align_lt_want) begin
          cmd.dbl_align = 1'b1;
        end else begin
          cmd.init_jump = 1'b1;
          state_nxt     = S_JUMP;
        end
      end
      S_JUMP: begin
        if (sts.jump_le_rows) begin
          cmd.init_row = 1'b1;
          state_nxt    = S_ROW;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_ROW: begin
        if (sts.row_lt_rows) begin
          cmd.init_ctx = 1'b1;
          state_nxt    = S_CTX;
        end else begin
          cmd.dbl_jump = 1'b1;
          state_nxt    = S_JUMP;
        end
      end
      S_CTX: begin
        if (sts.ctx_lt_n) begin
          cmd.latch_base = 1'b1;
          state_nxt      = S_TAG;
        end else begin
          cmd.step_row = 1'b1;
          state_nxt    = S_ROW;
        end
      end
      S_TAG: begin
        if (sts.tag_hit) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          cmd.sum_init = 1'b1;
          state_nxt    = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_done) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_CTX;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/ccra_dp.sv -----
// ----------------------------------------------------------------------------
// ccra_dp
// Datapath: config registers, tag and load-time stores, counters, best tracker.
// ----------------------------------------------------------------------------
module ccra_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ccra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccra_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [1:0]                          in_context_index,
  input  logic [4:0]                          in_row_index,
  input  logic [31:0]                         in_config_address,
  input  logic [31:0]                         in_load_time,
  input  logic [5:0]                          in_rows_wanted,
  input  logic [4:0]                          in_tag_row_offset,
  input  ccra_pkg::ccra_cmd_t                 cmd,
  output ccra_pkg::ccra_sts_t                 sts,
  output logic [4:0]                          out_start_row,
  output logic [5:0]                          out_end_row,
  output logic                                out_hit,
  output logic                                out_found
);

  localparam int IW = ccra_pkg::IDX_W;
  localparam int SW = ccra_pkg::STEP_W;

  // configuration
  logic [2:0] ctx_cnt_r;
  logic [5:0] row_cnt_r;
  logic [5:0] min_align_r;
  logic [5:0] nrows;
  logic [2:0] nctx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_cnt_r   <= 3'd1;
      row_cnt_r   <= 6'd32;
      min_align_r <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        ccra_pkg::CFG_CONTEXT_COUNT: ctx_cnt_r   <= cfg_wdata[2:0];
        ccra_pkg::CFG_ROW_COUNT:     row_cnt_r   <= cfg_wdata;
        ccra_pkg::CFG_MIN_ALIGNMENT: min_align_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nrows = (row_cnt_r > 6'(ccra_pkg::MAX_ROWS)) ? 6'(ccra_pkg::MAX_ROWS) : row_cnt_r;
  assign nctx  = (ctx_cnt_r > 3'(ccra_pkg::MAX_CONTEXTS)) ? 3'(ccra_pkg::MAX_CONTEXTS)
                                                          : ctx_cnt_r;

  // request registers and search counters
  logic            write_r;
  logic [31:0]     addr_r;
  logic [5:0]      want_r;
  logic [4:0]      offset_r;
  logic [6:0]      align_r;
  logic [SW-1:0]   jump_r;
  logic [SW-1:0]   row_r;
  logic [2:0]      ctx_r;
  logic [IW-1:0]   base_r;
  logic [5:0]      sum_idx_r;
  logic            pend_r;
  logic [ccra_pkg::SUM_W-1:0] acc_r;
  logic [ccra_pkg::SUM_W-1:0] best_r;
  logic [4:0]      start_r;
  logic            have_r;
  logic            hit_r;

  logic [IW-1:0]   base_comb;
  logic [IW-1:0]   tag_addr;
  logic [IW-1:0]   lt_addr;
  logic [IW-1:0]   wr_addr;
  logic [31:0]     tag_rd;
  logic [31:0]     lt_rd;

  assign base_comb = IW'(ctx_r) * IW'(nrows) + IW'(row_r);
  assign tag_addr  = base_comb + IW'(offset_r);
  assign lt_addr   = base_r + IW'(sum_idx_r);
  assign wr_addr   = IW'(in_context_index) * IW'(nrows) + IW'(in_row_index);

  // stores; valid bits give the all-zero reset content
  logic [31:0] tag_mem [ccra_pkg::STORE_DEPTH];
  logic [31:0] lt_mem  [ccra_pkg::STORE_DEPTH];
  logic [ccra_pkg::STORE_DEPTH-1:0] vld_r;
  logic [31:0] tag_q, lt_q;
  logic        tag_v_r, lt_v_r;
  logic        wr_ok;

  assign wr_ok = cmd.wr && (wr_addr < IW'(ccra_pkg::STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      tag_mem[wr_addr[ccra_pkg::ADDR_W-1:0]] <= in_config_address;
      lt_mem[wr_addr[ccra_pkg::ADDR_W-1:0]]  <= in_load_time;
    end
    tag_q <= tag_mem[tag_addr[ccra_pkg::ADDR_W-1:0]];
    lt_q  <= lt_mem[lt_addr[ccra_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      tag_v_r <= 1'b0;
      lt_v_r  <= 1'b0;
    end else begin
      if (wr_ok) vld_r[wr_addr[ccra_pkg::ADDR_W-1:0]] <= 1'b1;
      tag_v_r <= (tag_addr < IW'(ccra_pkg::STORE_DEPTH)) &&
                 vld_r[tag_addr[ccra_pkg::ADDR_W-1:0]];
      lt_v_r  <= (lt_addr < IW'(ccra_pkg::STORE_DEPTH)) &&
                 vld_r[lt_addr[ccra_pkg::ADDR_W-1:0]];
    end
  end

  assign tag_rd = tag_v_r ? tag_q : 32'd0;
  assign lt_rd  = lt_v_r ? lt_q : 32'd0;

  assign sts.align_lt_want = align_r < {1'b0, want_r};
  assign sts.jump_le_rows  = jump_r <= SW'(nrows);
  assign sts.row_lt_rows   = row_r < SW'(nrows);
  assign sts.ctx_lt_n      = ctx_r < nctx;
  assign sts.tag_hit       = (addr_r != 32'd0) && (tag_rd == addr_r);
  assign sts.sum_done      = (sum_idx_r >= want_r) && !pend_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      write_r  <= cmd.wr;
      addr_r   <= in_config_address;
      want_r   <= in_rows_wanted;
      offset_r <= (in_rows_wanted < {1'b0, in_tag_row_offset}) ? 5'd0 : in_tag_row_offset;
      align_r  <= (min_align_r == 6'd0) ? 7'd1 : {1'b0, min_align_r};
      start_r  <= 5'd0;
      have_r   <= 1'b0;
      hit_r    <= 1'b0;
    end
    if (cmd.dbl_align) align_r <= {align_r[5:0], 1'b0};
    if (cmd.init_jump) jump_r  <= SW'(align_r);
    if (cmd.dbl_jump)  jump_r  <= {jump_r[SW-2:0], 1'b0};
    if (cmd.init_row)  row_r   <= jump_r - SW'(align_r);
    if (cmd.step_row)  row_r   <= row_r + {jump_r[SW-2:0], 1'b0};
    if (cmd.init_ctx)  ctx_r   <= 3'd0;
    if (cmd.latch_base) base_r <= base_comb;
    if (cmd.set_hit) begin
      hit_r   <= 1'b1;
      have_r  <= 1'b1;
      start_r <= row_r[4:0];
    end
    if (cmd.sum_init) begin
      sum_idx_r <= 6'd0;
      acc_r     <= '0;
      pend_r    <= 1'b0;
    end
    if (cmd.sum_step) begin
      pend_r <= sum_idx_r < want_r;
      if (sum_idx_r < want_r) sum_idx_r <= sum_idx_r + 6'd1;
      if (pend_r) acc_r <= acc_r + ccra_pkg::SUM_W'(lt_rd);
    end
    if (cmd.cmp) begin
      ctx_r <= ctx_r + 3'd1;
      if (!have_r || acc_r < best_r) begin
        best_r  <= acc_r;
        start_r <= row_r[4:0];
        have_r  <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      if (write_r) begin
        out_start_row <= 5'd0;
        out_end_row   <= 6'd0;
        out_hit       <= 1'b0;
        out_found     <= 1'b1;
      end else begin
        out_start_row <= start_r;
        out_end_row   <= {1'b0, start_r} + want_r;
        out_hit       <= hit_r;
        out_found     <= have_r;
      end
    end
  end

endmodule

// ----- hw/rtl/config_cache_row_allocator.sv -----
// ----------------------------------------------------------------------------
// config_cache_row_allocator
// Row allocator for a multi-context configuration cache.
// ----------------------------------------------------------------------------
// One transaction at a time. A write skips the search and goes straight to the
// result state. An allocation walks aligned start rows in doubling-jump order and
// every context per row: each candidate costs one tag read and, on a miss, a
// load-time sum over rows_wanted rows through the single read port of the
// load-time store, plus a compare step; alignment rounding and loop stepping
// take further steps of their own. The result sits in an output register, so a
// new request is taken while the previous result waits. Both stores read as zero
// after reset through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module config_cache_row_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ccra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccra_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ccra_in_if.sink                          in_ch,
  ccra_out_if.source                       out_ch
);

  ccra_pkg::ccra_cmd_t cmd;
  ccra_pkg::ccra_sts_t sts;

  // sequencer
  ccra_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .sts         (sts),
    .cmd         (cmd)
  );

  // stores, counters, running minimum
  ccra_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_context_index  (in_ch.context_index),
    .in_row_index      (in_ch.row_index),
    .in_config_address (in_ch.config_address),
    .in_load_time      (in_ch.load_time),
    .in_rows_wanted    (in_ch.rows_wanted),
    .in_tag_row_offset (in_ch.tag_row_offset),
    .cmd               (cmd),
    .sts               (sts),
    .out_start_row     (out_ch.start_row),
    .out_end_row       (out_ch.end_row),
    .out_hit           (out_ch.hit),
    .out_found         (out_ch.found)
  );

  // a hit always means a row was found
  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.hit || out_ch.found))
    else $error("hit without found");

  // no candidate reports start row zero
  a_nofound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.start_row == 5'd0))
    else $error("nonzero start row without candidate");

  // a new request is never taken in the same cycle a result is loaded
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !cmd.out_load)
    else $error("accept during result load");

endmodule

// ----- verif/tb_config_cache_row_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_config_cache_row_allocator
// Self-checking bench for the row allocator. Requests go in through the
// valid/ready request channel and results come back on the result channel.
// A behavioral copy of the tag and load-time stores predicts each result.
// Directed checks come first, then a long random run over many register
// settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_config_cache_row_allocator;

  localparam int WATCHDOG_LIMIT = 60000;  // idle cycles with no transaction
  localparam int LONG_STALL     = 400;

  typedef struct {
    logic        req_type;
    logic [1:0]  context_index;
    logic [4:0]  row_index;
    logic [31:0] config_address;
    logic [31:0] load_time;
    logic [5:0]  rows_wanted;
    logic [4:0]  tag_row_offset;
  } row_req_t;

  typedef struct {
    logic [4:0] start_row;
    logic [5:0] end_row;
    logic       hit;
    logic       found;
  } row_grant_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ccra_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ccra_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ccra_in_if  in_ch ();
  ccra_out_if out_ch ();

  config_cache_row_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // Clock, 20 ns period
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shadow copy of the block state
  logic [31:0] tag_mem  [ccra_pkg::STORE_DEPTH];
  logic [31:0] ltime_mem[ccra_pkg::STORE_DEPTH];
  logic [2:0]  ctx_cfg;
  logic [5:0]  rows_cfg;
  logic [5:0]  align_cfg;

  row_grant_t grant_q[$];
  int         mismatches;
  int         burst_left;
  bit         hold_off;      // request for a long receiver stall
  int         idle_cycles;

  function automatic logic [31:0] tag_at(longint unsigned idx);
    return idx < ccra_pkg::STORE_DEPTH ? tag_mem[idx] : 32'd0;
  endfunction

  function automatic logic [31:0] ltime_at(longint unsigned idx);
    return idx < ccra_pkg::STORE_DEPTH ? ltime_mem[idx] : 32'd0;
  endfunction

  // Predicts the grant for one request and updates the shadow stores on writes.
  function automatic row_grant_t predict_grant(row_req_t r);
    row_grant_t g;
    int unsigned nrows, nctx, want, offs, align, start, jump, row, c, k;
    longint unsigned base, sum, best;
    bit have, hit;
    nrows = rows_cfg > ccra_pkg::MAX_ROWS ? ccra_pkg::MAX_ROWS : rows_cfg;
    nctx  = ctx_cfg > ccra_pkg::MAX_CONTEXTS ? ccra_pkg::MAX_CONTEXTS : ctx_cfg;
    g = '{5'd0, 6'd0, 1'b0, 1'b1};
    if (r.req_type == ccra_pkg::REQ_WRITE) begin
      base = longint'(r.context_index) * nrows + r.row_index;
      if (base < ccra_pkg::STORE_DEPTH) begin
        tag_mem[base]   = r.config_address;
        ltime_mem[base] = r.load_time;
      end
      return g;
    end
    want  = r.rows_wanted;
    offs  = (want < r.tag_row_offset) ? 0 : r.tag_row_offset;
    align = (align_cfg == 0) ? 1 : align_cfg;
    while (align < want) align = align << 1;
    have = 0;
    hit  = 0;
    best = 0;
    start = 0;
    for (jump = align; jump <= nrows && !hit; jump += jump) begin
      for (row = jump - align; row < nrows && !hit; row += 2 * jump) begin
        for (c = 0; c < nctx; c++) begin
          base = longint'(c) * nrows + row;
          if (r.config_address != 0 && tag_at(base + offs) == r.config_address) begin
            start = row;
            hit   = 1;
            have  = 1;
            break;
          end
          sum = 0;
          for (k = 0; k < want; k++) sum += ltime_at(base + k);
          if (!have || sum < best) begin
            best  = sum;
            start = row;
            have  = 1;
          end
        end
      end
    end
    if (!have) start = 0;
    g.start_row = start[4:0];
    g.end_row   = 6'(start + want);
    g.hit       = hit;
    g.found     = have;
    return g;
  endfunction

  // Receiver: own stall pattern, plus a long hold-off on request
  int stall_phase;
  int hold_count;
  always @(negedge clk) begin
    if (hold_off && hold_count == 0) hold_count = LONG_STALL;
    if (hold_count > 0) begin
      hold_count--;
      if (hold_count == 0) hold_off = 0;
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 97;
      if (stall_phase < 30) out_ch.ready <= 1'b1;              // no stalls here
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    row_grant_t exp_g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result transaction start_row=%0d", out_ch.start_row);
        mismatches++;
      end else begin
        exp_g = grant_q.pop_front();
        if (out_ch.start_row !== exp_g.start_row) begin
          $error("start_row expected %0d actual %0d", exp_g.start_row, out_ch.start_row);
          mismatches++;
        end
        if (out_ch.end_row !== exp_g.end_row) begin
          $error("end_row expected %0d actual %0d", exp_g.end_row, out_ch.end_row);
          mismatches++;
        end
        if (out_ch.hit !== exp_g.hit) begin
          $error("hit expected %0d actual %0d", exp_g.hit, out_ch.hit);
          mismatches++;
        end
        if (out_ch.found !== exp_g.found) begin
          $error("found expected %0d actual %0d", exp_g.found, out_ch.found);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_config_cache_row_allocator: FAIL");
      $finish;
    end
  end

  // Sends one request transaction; returns right after the accepting edge.
  task automatic send_req(row_req_t r);
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 10);
    end
    in_ch.req_type       <= r.req_type;
    in_ch.context_index  <= r.context_index;
    in_ch.row_index      <= r.row_index;
    in_ch.config_address <= r.config_address;
    in_ch.load_time      <= r.load_time;
    in_ch.rows_wanted    <= r.rows_wanted;
    in_ch.tag_row_offset <= r.tag_row_offset;
    in_ch.valid          <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    grant_q.push_back(predict_grant(r));
    burst_left--;
  endtask

  // Stops offering and waits until every expected result is back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Register writes, only with the block idle.
  task automatic set_config(logic [2:0] nctx, logic [5:0] nrows, logic [5:0] align);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= ccra_pkg::CFG_CONTEXT_COUNT; cfg_wdata <= {3'd0, nctx};
    @(negedge clk);
    cfg_index <= ccra_pkg::CFG_ROW_COUNT; cfg_wdata <= nrows;
    @(negedge clk);
    cfg_index <= ccra_pkg::CFG_MIN_ALIGNMENT; cfg_wdata <= align;
    @(negedge clk);
    cfg_we <= 1'b0;
    ctx_cfg   = nctx;
    rows_cfg  = nrows;
    align_cfg = align;
  endtask

  function automatic row_req_t wr_req(int c, int r, logic [31:0] tag, logic [31:0] lt);
    return '{ccra_pkg::REQ_WRITE, 2'(c), 5'(r), tag, lt, 6'($urandom), 5'($urandom)};
  endfunction

  function automatic row_req_t alloc_req(logic [31:0] addr, int want, int offs);
    return '{ccra_pkg::REQ_ALLOCATE, 2'($urandom), 5'($urandom), addr, $urandom,
             6'(want), 5'(offs)};
  endfunction

  // Fresh stores after reset: every sum is zero, first candidate wins.
  task automatic test_reset_state();
    send_req(alloc_req(32'd0, 1, 0));
    send_req(alloc_req(32'hFFFF_FFFF, 32, 31));
    drain();
  endtask

  // Writes, tag hits, offset clamp, least-used choice, zero and oversize sizes.
  task automatic test_hit_and_lru();
    set_config(3'd4, 6'd32, 6'd1);
    send_req(wr_req(2, 8, 32'hDEAD_BEEF, 32'hFFFF_FFFF));
    send_req(wr_req(3, 31, 32'hFFFF_FFFF, 32'd7));
    send_req(wr_req(0, 0, 32'd5, 32'd100));
    send_req(alloc_req(32'hDEAD_BEEF, 8, 0));     // hit at offset 0
    send_req(alloc_req(32'hDEAD_BEEF, 4, 4));     // hit via offset
    send_req(alloc_req(32'hDEAD_BEEF, 2, 6));     // offset above count drops to 0
    send_req(alloc_req(32'hFFFF_FFFF, 1, 0));     // tag in last entry
    send_req(alloc_req(32'd0, 1, 0));             // no lookup, least load time
    send_req(alloc_req(32'd9, 0, 0));             // zero rows wanted
    send_req(alloc_req(32'd9, 63, 31));           // oversize request
    drain();
  endtask

  // Register extremes: no contexts, no rows, clipping, odd and zero alignment.
  task automatic test_config_extremes();
    set_config(3'd0, 6'd32, 6'd1);
    send_req(alloc_req(32'd5, 1, 0));             // no candidate
    drain();
    set_config(3'd7, 6'd0, 6'd0);
    send_req(alloc_req(32'd5, 3, 1));             // no rows, no candidate
    send_req(wr_req(1, 31, 32'd77, 32'd1));       // row past count aliases
    drain();
    set_config(3'd7, 6'd63, 6'd63);
    send_req(alloc_req(32'd0, 2, 0));
    drain();
    set_config(3'd2, 6'd5, 6'd0);
    send_req(alloc_req(32'd77, 2, 0));
    send_req(alloc_req(32'd0, 33, 0));
    drain();
  endtask

  // Random traffic; tags from a small pool so lookups hit often.
  task automatic test_random(int n_items);
    row_req_t r;
    logic [31:0] pool[8];
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = 32'hFFFF_FFFF;
    for (int i = 0; i < n_items; i++) begin
      if (i % 250 == 0) begin
        drain();
        case ($urandom_range(0, 5))
          0: set_config(3'd4, 6'd32, 6'd1);
          1: set_config(3'($urandom_range(0, 7)), 6'($urandom), 6'($urandom));
          2: set_config(3'd1, 6'($urandom_range(1, 32)), 6'd32);
          default: set_config(3'($urandom_range(1, 4)), 6'($urandom_range(1, 32)),
                              6'(1 << $urandom_range(0, 5)));
        endcase
      end
      if (i == n_items / 2) hold_off = 1;        // receiver holds off, sender keeps going
      if (i == n_items / 3) drain();             // sender waits for every result
      if ($urandom_range(0, 9) < 6) begin
        r = wr_req($urandom_range(0, 3), $urandom_range(0, 31),
                   ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 7)],
                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom);
      end else begin
        r = alloc_req(($urandom_range(0, 4) == 0) ? 32'd0 :
                      ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 7)],
                      ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(1, 8),
                      $urandom_range(0, 31));
      end
      send_req(r);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ccra_pkg::CFG_CONTEXT_COUNT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = ccra_pkg::REQ_WRITE;
    in_ch.context_index = '0;
    in_ch.row_index = '0;
    in_ch.config_address = '0;
    in_ch.load_time = '0;
    in_ch.rows_wanted = '0;
    in_ch.tag_row_offset = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    burst_left = 0;
    hold_off = 0;
    hold_count = 0;
    stall_phase = 0;
    idle_cycles = 0;
    foreach (tag_mem[i]) begin
      tag_mem[i] = '0;
      ltime_mem[i] = '0;
    end
    ctx_cfg = 3'd1;
    rows_cfg = 6'd32;
    align_cfg = 6'd1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_hit_and_lru();
    test_config_extremes();
    test_random(1880);

    repeat (20) @(negedge clk);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("tb_config_cache_row_allocator: PASS");
    end else begin
      $display("tb_config_cache_row_allocator: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ccra_pkg.sv
hw/rtl/ccra_if.sv
hw/rtl/ccra_ctrl.sv
hw/rtl/ccra_dp.sv
hw/rtl/config_cache_row_allocator.sv
verif/tb_config_cache_row_allocator.sv
